/* sv/p2c_pkg.sv */
// Shared types and constants for the polar to cartesian converter.
// Holds the opcode codes, the vector type and the arctangent table.
// No dependencies.
package p2c_pkg;

	localparam int FRAC_BITS = 12;
	localparam int MAG_W     = 16;
	localparam int ANG_W     = 16;
	localparam int XY_W      = 31;
	localparam int Z_W       = 32;
	localparam int OUT_W     = 17;
	localparam int TABLE_LEN = 24;
	localparam int PROD_W    = XY_W + 33;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [31:0] GAIN_K = 32'h9B74EDA9;
	localparam logic signed [19:0] OUT_MAX = 20'sd65535;

	typedef enum logic [1:0] {
		OP_DIRECT   = 2'd0,
		OP_MIRROR_X = 2'd1,
		OP_MIRROR_Y = 2'd2,
		OP_OPPOSITE = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} vec_t;

	localparam logic [31:0] ATAN_TAB [0:TABLE_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

endpackage

/* sv/p2c_pre.sv */
// Front stage: effective angle from the opcode and quadrant reduction.
// Depends on p2c_pkg.
module p2c_pre (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic [p2c_pkg::MAG_W-1:0]      magnitude,
	input  logic [p2c_pkg::ANG_W-1:0]      angle,
	output logic                           out_valid,
	input  logic                           out_ready,
	output p2c_pkg::vec_t                  out_vec
);

	logic [p2c_pkg::ANG_W-1:0] a16;
	logic                      flip;
	logic signed [p2c_pkg::XY_W-1:0] x0;
	p2c_pkg::vec_t             vec_d;
	p2c_pkg::vec_t             vec_s1;
	logic                      valid_s1;

	always_comb begin
		case (p2c_pkg::op_t'(opcode))
			p2c_pkg::OP_DIRECT:   a16 = angle;
			p2c_pkg::OP_MIRROR_X: a16 = 16'h8000 - angle;
			p2c_pkg::OP_MIRROR_Y: a16 = 16'h0000 - angle;
			p2c_pkg::OP_OPPOSITE: a16 = 16'h8000 + angle;
			default:              a16 = angle;
		endcase
		flip = a16[15] ^ a16[14];
		x0 = $signed({3'b000, magnitude, {p2c_pkg::FRAC_BITS{1'b0}}});
		vec_d.x = flip ? -x0 : x0;
		vec_d.y = '0;
		vec_d.z = $signed({a16[15] ^ flip, a16[14:0], 16'h0000});
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= vec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

/* sv/p2c_rot_stage.sv */
// One CORDIC micro-rotation as a registered pipeline stage.
// Depends on p2c_pkg for the vector type and the arctangent table.
module p2c_rot_stage #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  p2c_pkg::vec_t in_vec,
	output logic          out_valid,
	input  logic          out_ready,
	output p2c_pkg::vec_t out_vec
);

	logic signed [p2c_pkg::XY_W-1:0] dx;
	logic signed [p2c_pkg::XY_W-1:0] dy;
	logic signed [p2c_pkg::Z_W-1:0]  da;
	p2c_pkg::vec_t vec_d;
	p2c_pkg::vec_t vec_s1;
	logic          valid_s1;

	always_comb begin
		dx = in_vec.y >>> STEP;
		dy = in_vec.x >>> STEP;
		da = $signed(p2c_pkg::ATAN_TAB[STEP]);
		if (!in_vec.z[p2c_pkg::Z_W-1]) begin
			vec_d.x = in_vec.x - dx;
			vec_d.y = in_vec.y + dy;
			vec_d.z = in_vec.z - da;
		end else begin
			vec_d.x = in_vec.x + dx;
			vec_d.y = in_vec.y - dy;
			vec_d.z = in_vec.z + da;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= vec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

/* sv/p2c_gain.sv */
// Gain compensation: multiply by the CORDIC gain, then round and saturate.
// Two register stages. Depends on p2c_pkg.
module p2c_gain (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  p2c_pkg::vec_t                      in_vec,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [p2c_pkg::OUT_W-1:0]   x_coord,
	output logic signed [p2c_pkg::OUT_W-1:0]   y_coord
);

	localparam int SHIFT = 32 + p2c_pkg::FRAC_BITS;
	localparam int R_W   = p2c_pkg::PROD_W - SHIFT;

	logic signed [32:0]                   gain;
	logic signed [p2c_pkg::PROD_W-1:0]    prod_x_s1;
	logic signed [p2c_pkg::PROD_W-1:0]    prod_y_s1;
	logic                                 valid_s1;
	logic                                 ready_s1;
	logic signed [p2c_pkg::OUT_W-1:0]     x_s2;
	logic signed [p2c_pkg::OUT_W-1:0]     y_s2;
	logic                                 valid_s2;
	logic signed [p2c_pkg::PROD_W-1:0]    half;
	logic signed [p2c_pkg::PROD_W-1:0]    sum_x;
	logic signed [p2c_pkg::PROD_W-1:0]    sum_y;
	logic signed [R_W-1:0]                r_x;
	logic signed [R_W-1:0]                r_y;
	logic signed [p2c_pkg::OUT_W-1:0]     sat_x;
	logic signed [p2c_pkg::OUT_W-1:0]     sat_y;

	function automatic logic signed [p2c_pkg::OUT_W-1:0] clamp(input logic signed [R_W-1:0] r);
		logic signed [R_W-1:0] lim;
		lim = R_W'(p2c_pkg::OUT_MAX);
		if (r > lim) begin
			clamp = p2c_pkg::OUT_W'(lim);
		end else if (r < -lim) begin
			clamp = p2c_pkg::OUT_W'(-lim);
		end else begin
			clamp = r[p2c_pkg::OUT_W-1:0];
		end
	endfunction

	assign gain = $signed({1'b0, p2c_pkg::GAIN_K});

	assign ready_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_x_s1 <= p2c_pkg::PROD_W'(in_vec.x * gain);
			prod_y_s1 <= p2c_pkg::PROD_W'(in_vec.y * gain);
		end
	end

	always_comb begin
		half  = $signed({{(p2c_pkg::PROD_W-1){1'b0}}, 1'b1}) <<< (SHIFT - 1);
		sum_x = prod_x_s1 + half;
		sum_y = prod_y_s1 + half;
		r_x   = sum_x[p2c_pkg::PROD_W-1:SHIFT];
		r_y   = sum_y[p2c_pkg::PROD_W-1:SHIFT];
		sat_x = clamp(r_x);
		sat_y = clamp(r_y);
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			x_s2 <= sat_x;
			y_s2 <= sat_y;
		end
	end

	assign out_valid = valid_s2;
	assign x_coord   = x_s2;
	assign y_coord   = y_s2;

endmodule

/* sv/polar_to_cartesian_mirror_core.sv */
// Polar to cartesian converter with mirror modes, fully pipelined CORDIC.
// Pipeline: one quadrant stage, one stage per micro-rotation (ROTATION_STEPS, at most 24),
// then the multiply and round stages.
// Throughput: one request per cycle; every stage holds its request on backpressure.
// Reset: arst_n asynchronously clears all valid bits; data registers are not reset.
// Depends on p2c_pkg, p2c_pre, p2c_rot_stage and p2c_gain.
module polar_to_cartesian_mirror_core #(
	parameter int ROTATION_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [1:0] opcode, [17:2] magnitude, [33:18] angle, [39:34] zero
	input  logic [p2c_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [16:0] x_coord, [33:17] y_coord, [39:34] zero
	output logic [p2c_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int STEPS = (ROTATION_STEPS > p2c_pkg::TABLE_LEN) ?
		p2c_pkg::TABLE_LEN : ROTATION_STEPS;

	p2c_pkg::vec_t vec   [0:STEPS];
	logic          valid [0:STEPS];
	logic          ready [0:STEPS];
	logic          gain_ready;
	logic signed [p2c_pkg::OUT_W-1:0] x_coord;
	logic signed [p2c_pkg::OUT_W-1:0] y_coord;

	p2c_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.opcode    (s_tdata[1:0]),
		.magnitude (s_tdata[17:2]),
		.angle     (s_tdata[33:18]),
		.out_valid (valid[0]),
		.out_ready (ready[0]),
		.out_vec   (vec[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		p2c_rot_stage #(
			.STEP (i)
		) u_rot (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[i]),
			.in_ready  (ready[i]),
			.in_vec    (vec[i]),
			.out_valid (valid[i+1]),
			.out_ready (ready[i+1]),
			.out_vec   (vec[i+1])
		);
	end

	assign ready[STEPS] = gain_ready;

	p2c_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid[STEPS]),
		.in_ready  (gain_ready),
		.in_vec    (vec[STEPS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.x_coord   (x_coord),
		.y_coord   (y_coord)
	);

	assign m_tdata = {{(p2c_pkg::OUT_TDATA_W - 2*p2c_pkg::OUT_W){1'b0}}, y_coord, x_coord};

endmodule
